// ===== rtl/s2a_pkg.sv =====
// shared types and constants for the signed integer to decimal ascii core
// no dependencies
package s2a_pkg;

    localparam int MAG_W = 32;
    localparam int CHAR_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

    // floor(x / 10) == (x * RECIP_10) >> DIV_SHIFT for every 32-bit x
    localparam logic [MAG_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int DIV_SHIFT = 35;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_item;

endpackage

// ===== rtl/s2a_front.sv =====
// front stage: takes the input word, splits it into sign and 32-bit magnitude
// depends on s2a_pkg
module s2a_front
    import s2a_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [MAG_W-1:0] i_value,
    output logic             o_valid,
    input  logic             i_ready,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item = r_item;

    always_comb begin
        n_item.neg = i_value[MAG_W-1];
        n_item.mag = i_value[MAG_W-1] ? (MAG_W'(0) - i_value) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/s2a_fifo.sv =====
// two-entry queue between the front and back stages
// depends on s2a_pkg
module s2a_fifo
    import s2a_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item = r_mem[r_rd_ptr];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/s2a_back.sv =====
// back stage: divide-by-ten loop into a digit buffer, then character output
// depends on s2a_pkg
module s2a_back
    import s2a_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_ovalid, n_ovalid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic [3:0]        r_digs [MAX_DIGITS];

    logic [2*MAG_W-1:0] w_prod;
    logic [MAG_W-1:0]   w_quo;
    logic [MAG_W-1:0]   w_rem;
    logic               w_wr;
    logic               w_free;

    // quotient by reciprocal, remainder by shift-and-add back-multiply
    assign w_prod = {{MAG_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, RECIP_10};
    assign w_quo = MAG_W'(w_prod[2*MAG_W-1:DIV_SHIFT]);
    assign w_rem = r_mag - ({w_quo[MAG_W-4:0], 3'b000} + {w_quo[MAG_W-2:0], 1'b0});

    assign w_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_character = r_char;
    assign o_last = r_last;

    always_comb begin
        n_state = r_state;
        n_mag = r_mag;
        n_neg = r_neg;
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_ovalid = r_ovalid && !i_ready;
        n_char = r_char;
        n_last = r_last;
        w_wr = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mag = i_item.mag;
                    n_neg = i_item.neg;
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // at least one digit, so zero still prints '0'
                w_wr = 1'b1;
                n_mag = w_quo;
                n_cnt = r_cnt + 1'b1;
                if ((w_quo == '0) || (n_cnt == CNT_W'(MAX_DIGITS))) begin
                    n_idx = r_cnt[IDX_W-1:0];
                    n_state = S_EMIT;
                end
                // minus sign goes out while the digits are still being formed, if the output is free
                if (r_neg && w_free) begin
                    n_ovalid = 1'b1;
                    n_char = CHAR_MINUS;
                    n_last = 1'b0;
                    n_neg = 1'b0;
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                        n_neg = 1'b0;
                    end else begin
                        n_char = CHAR_ZERO + {2'b00, r_digs[r_idx]};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_neg <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_neg <= n_neg;
        end
        r_mag <= n_mag;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
        if (w_wr) begin
            r_digs[r_cnt[IDX_W-1:0]] <= w_rem[3:0];
        end
    end

endmodule

// ===== rtl/signed_integer_to_decimal_ascii_core.sv =====
// top level of the signed integer to decimal ascii core
// depends on s2a_pkg, s2a_front, s2a_fifo, s2a_back
//
// usage
//   input channel: i_valid / o_ready with i_value, one signed 32-bit word
//   output channel: o_valid / i_ready with o_character (6-bit ascii code)
//     and o_last, high on the final character of each number
//   each number becomes '-' (negative only) followed by its digits, most
//     significant first, no leading zeros; zero prints as a single '0'
//   the front stage registers the word as sign and magnitude, a two-entry
//     queue holds up to two more, so three words can be taken ahead
//   the back stage runs one divide-by-ten step per cycle (reciprocal
//     multiply), one step per digit, 1 to MAX_DIGITS digits, then sends
//     one digit per cycle while the receiver is ready; the minus sign
//     leaves during the divide loop if the output is free, else it goes
//     out first in the digit pass
//   the back stage takes the next number only after the last digit of
//     the previous one; take step, divide loop and digit pass set its pace
//   a stalled receiver holds the output register; the back stage waits,
//     the queue fills, and o_ready drops once front and queue are full
//   synchronous active-low reset empties the queue and the output register
module signed_integer_to_decimal_ascii_core
    import s2a_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MAG_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    // front to queue
    logic  w_fr_valid;
    logic  w_fr_ready;
    t_item w_fr_item;

    // queue to back
    logic  w_q_valid;
    logic  w_q_ready;
    t_item w_q_item;

    s2a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_item  (w_fr_item)
    );

    s2a_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_item  (w_fr_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // divide loop and character sequencer
    s2a_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_item      (w_q_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/s2a_checker.sv =====
// port-level checks for the signed integer to decimal ascii core, with bind
// depends on s2a_pkg, signed_integer_to_decimal_ascii_core
module s2a_checker
    import s2a_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CHAR_W-1:0] o_character,
    input logic              o_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output word changed while stalled");

    a_char_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CHAR_MINUS) ||
                    ((o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 6'd9)))
        else $error("character is neither minus nor digit");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as last");

    // two minus signs in a row cannot come from one number
    a_no_double_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_character == CHAR_MINUS) ##1 o_valid
        |-> (o_character != CHAR_MINUS))
        else $error("minus sign repeated");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind signed_integer_to_decimal_ascii_core s2a_checker u_s2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_character (o_character),
    .o_last      (o_last)
);

// ===== tb/sv/signed_integer_to_decimal_ascii_core_tb.sv =====
// testbench for signed_integer_to_decimal_ascii_core: renders each accepted word into
// its expected decimal characters and checks them in order against the output channel
// depends on s2a_pkg and signed_integer_to_decimal_ascii_core
module signed_integer_to_decimal_ascii_core_tb
    import s2a_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS = 10;
    // the worst case stays well under this limit, which leaves plenty of room
    localparam int CYCLE_LIMIT = 200000;
    // the front stage, the queue and the back stage are all empty well before this
    localparam int SETTLE_CYCLES = 40;

    // one expected output character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    // keeps the characters still owed by the block, oldest first
    class ascii_text_tracker;
        t_text_char pending_chars[$];
        int         errors;
        int         digit_cap;

        function new(int digit_cap);
            this.digit_cap = digit_cap;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // turn an accepted word into the characters it must produce
        function void render_word(logic [MAG_W-1:0] value);
            logic [MAG_W-1:0] mag;
            logic [3:0]       digits[$];
            t_text_char       c;
            int               i;
            if (value == '0) begin
                c.ch = CHAR_ZERO;
                c.last = 1'b1;
                pending_chars.push_back(c);
                return;
            end
            if (value[MAG_W-1]) begin
                c.ch = CHAR_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
                mag = -value;
            end else begin
                mag = value;
            end
            // least significant digit first, only as many as the buffer holds
            while (mag != '0 && digits.size() < digit_cap) begin
                digits.push_back(4'(mag % 10));
                mag = mag / 10;
            end
            for (i = digits.size() - 1; i >= 0; i--) begin
                c.ch = CHAR_ZERO + CHAR_W'(digits[i]);
                c.last = (i == 0);
                pending_chars.push_back(c);
            end
        endfunction

        task check_char(logic [CHAR_W-1:0] ch, logic last);
            t_text_char exp_c;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("char %0d last %0b with nothing pending", ch, last));
                return;
            end
            exp_c = pending_chars.pop_front();
            if (ch !== exp_c.ch) begin
                report_mismatch($sformatf("char %0d, want %0d", ch, exp_c.ch));
            end
            if (last !== exp_c.last) begin
                report_mismatch($sformatf("last %0b on char %0d, want %0b", last, exp_c.ch,
                                          exp_c.last));
            end
        endtask
    endclass

    // every input starts at a known value
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [MAG_W-1:0]  i_value = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [CHAR_W-1:0] o_character;
    logic              o_last;

    // percent of cycles in which each side holds off
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                cycle_count = 0;

    ascii_text_tracker text_track = new(MAX_DIGITS);

    signed_integer_to_decimal_ascii_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_character(o_character),
        .o_last     (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: values read right after the edge are the ones the edge saw,
    // so a character counts when valid and ready were both high there
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                text_track.check_char(o_character, o_last);
            end
            i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // offer one word, with random hold-off first; valid stays up until the
    // edge that takes it, and is left high so back-to-back words need no gap
    task automatic send_word(input logic [MAG_W-1:0] value);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        text_track.render_word(value);
    endtask

    // random word: three in ten fully random bits, one in ten zero or a range
    // end, the rest spread over digit counts so all lengths show up equally, both signs
    function automatic logic [MAG_W-1:0] pick_word();
        int          kind;
        int          ndig;
        longint      lo;
        longint      hi;
        logic [MAG_W-1:0] mag;
        kind = $urandom_range(9, 0);
        if (kind < 3) begin
            return $urandom();
        end
        if (kind == 3) begin
            // zero and the two ends of the range now and then
            case ($urandom_range(2, 0))
                0: return '0;
                1: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483647) begin
            hi = 64'd2147483647;
        end
        mag = $urandom_range(32'(hi), 32'(lo));
        return $urandom_range(1, 0) ? -mag : mag;
    endfunction

    // zero, single digits, powers of ten, the range ends and the most
    // negative value whose magnitude does not fit in 31 bits
    logic [MAG_W-1:0] corner_words[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd100, 32'd101, 32'd999999999, 32'd1000000000, -32'sd1000000000,
        32'd1000000009, 32'd1234567890, -32'sd1234567890, 32'h7FFF_FFFF,
        -32'sd2147483647, 32'h8000_0000, 32'd5, -32'sd5
    };

    initial begin
        int phase;
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (phase = 0; phase < 3; phase++) begin
            // sender light and receiver heavy, then swapped, then full rate
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                foreach (corner_words[k]) send_word(corner_words[k]);
            end
            for (n = 0; n < (phase == 0 ? 65 : 85); n++) begin
                send_word(pick_word());
            end
        end
        i_valid <= 1'b0;

        // drain everything still owed, then give the pipeline time to show
        // any stray character
        while (text_track.pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (text_track.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== signed_integer_to_decimal_ascii_core.f =====
rtl/s2a_pkg.sv
rtl/s2a_front.sv
rtl/s2a_fifo.sv
rtl/s2a_back.sv
rtl/signed_integer_to_decimal_ascii_core.sv
rtl/s2a_checker.sv
tb/sv/signed_integer_to_decimal_ascii_core_tb.sv
